// ===== hdl/next_lexicographic_permutation_assert.svh =====
// assertion macros for the next lexicographic permutation block
// used by files that hold concurrent checks; expects clk and rst in scope
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_ASSERT_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define NLP_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("nlp check failed");
`define NLP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlp check failed");
`define NLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlp check failed");
`else
`define NLP_ASSERT_ALWAYS(label, expr)
`define NLP_ASSERT_IMP(label, ante, cons)
`define NLP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/nlp_pkg.sv =====
// shared constants for the next lexicographic permutation block
// no dependencies
`timescale 1ns / 1ps
package nlp_pkg;
  localparam int MAX_LEN    = 16;
  localparam int VALUE_BITS = 16;
  localparam int RESULT_CAP = 16;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int ELEM_W     = 16;
  localparam int POS_W      = 4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;
endpackage

// ===== hdl/nlp_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module nlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/next_lexicographic_permutation.sv =====
// top level of the next lexicographic permutation engine
// depends on nlp_pkg, nlp_ram and next_lexicographic_permutation_assert.svh
`timescale 1ns / 1ps
`include "next_lexicographic_permutation_assert.svh"
// usage
//   input channel: one transaction per item (op, value, last_in), taken when
//   in_valid is high and in_stall is low. op load appends value to the held
//   array (a load after a completed load starts a new array, loads past
//   capacity are dropped); op advance permutes the array and emits it.
//   in_stall is high whenever the sequencer is busy with an advance.
//   an advance on n held elements walks one ram read port: an ascent scan
//   that reads and compares each element, a successor scan that reads and
//   compares each candidate, a read, read, write, write swap per pair plus a
//   pass check, then a read and an output step per emitted element. the
//   single read port of the element ram paces this walk.
//   output channel: one transaction per element (elem_value, position,
//   last_out, wrapped), held in an output register; while out_stall is high
//   the register holds and the sequencer waits on that element.
//   an advance on an empty array gives no output transaction.
//   reset (rst, synchronous) empties the array, marks the load complete and
//   drops any pending output; the element ram itself is not cleared.
module next_lexicographic_permutation (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [15:0]               value,
  input  logic                      last_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [nlp_pkg::ELEM_W-1:0] elem_value,
  output logic [nlp_pkg::POS_W-1:0]  position,
  output logic                      last_out,
  output logic                      wrapped
);
  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ASC_RD  = 4'd1;
  localparam logic [3:0] S_ASC_CMP = 4'd2;
  localparam logic [3:0] S_SUC_RD  = 4'd3;
  localparam logic [3:0] S_SUC_CMP = 4'd4;
  localparam logic [3:0] S_RD_LO   = 4'd5;
  localparam logic [3:0] S_RD_HI   = 4'd6;
  localparam logic [3:0] S_WR_LO   = 4'd7;
  localparam logic [3:0] S_WR_HI   = 4'd8;
  localparam logic [3:0] S_CHK     = 4'd9;
  localparam logic [3:0] S_EM_RD   = 4'd10;
  localparam logic [3:0] S_EM_OUT  = 4'd11;

  logic [3:0]                        state;
  logic [nlp_pkg::LEN_W-1:0]         length;
  logic                              load_complete;
  logic [nlp_pkg::IDX_W-1:0]         k;        // ascent scan and emit index
  logic [nlp_pkg::IDX_W-1:0]         j;        // successor scan index
  logic [nlp_pkg::IDX_W-1:0]         lo;
  logic [nlp_pkg::IDX_W-1:0]         hi;
  logic [nlp_pkg::IDX_W-1:0]         pivot;
  logic [nlp_pkg::VALUE_BITS-1:0]    pv;       // pivot value
  logic [nlp_pkg::VALUE_BITS-1:0]    prev;     // element right of k
  logic [nlp_pkg::VALUE_BITS-1:0]    tmp;      // low side of a swap
  logic                              rev_phase; // 0 while doing the pivot swap
  logic                              wrap;

  logic                              accept;
  logic [nlp_pkg::LEN_W-1:0]         eff_len;
  logic [nlp_pkg::LEN_W-1:0]         len_m1;
  logic [nlp_pkg::LEN_W-1:0]         cnt_m1;
  logic                              emit_last;
  logic                              out_free;

  logic                              ram_we;
  logic [nlp_pkg::IDX_W-1:0]         ram_waddr;
  logic [nlp_pkg::VALUE_BITS-1:0]    ram_wdata;
  logic [nlp_pkg::IDX_W-1:0]         ram_raddr;
  logic [nlp_pkg::VALUE_BITS-1:0]    ram_rdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // a load after a completed load restarts the array
  assign eff_len  = load_complete ? '0 : length;
  assign len_m1   = length - nlp_pkg::LEN_W'(1);
  assign cnt_m1   = ((length < nlp_pkg::LEN_W'(nlp_pkg::RESULT_CAP)) ? length
                    : nlp_pkg::LEN_W'(nlp_pkg::RESULT_CAP)) - nlp_pkg::LEN_W'(1);
  assign emit_last = (nlp_pkg::LEN_W'(k) == cnt_m1);
  assign out_free  = !out_valid || !out_stall;

  // element ram ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo;
    ram_wdata = ram_rdata;
    case (state)
      S_IDLE: begin
        ram_we    = accept && (op == nlp_pkg::OP_LOAD)
                    && (eff_len < nlp_pkg::LEN_W'(nlp_pkg::MAX_LEN));
        ram_waddr = eff_len[nlp_pkg::IDX_W-1:0];
        ram_wdata = value[nlp_pkg::VALUE_BITS-1:0];
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata;
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = tmp;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_SUC_RD: ram_raddr = j;
      S_RD_LO:  ram_raddr = lo;
      S_RD_HI:  ram_raddr = hi;
      default:  ram_raddr = k;
    endcase
  end

  nlp_ram #(
    .WIDTH (nlp_pkg::VALUE_BITS),
    .DEPTH (nlp_pkg::MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      length        <= '0;
      load_complete <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      // in the emit state the output register is refilled below
      if (out_valid && !out_stall && (state != S_EM_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == nlp_pkg::OP_LOAD) begin
              if (eff_len < nlp_pkg::LEN_W'(nlp_pkg::MAX_LEN)) begin
                length <= eff_len + nlp_pkg::LEN_W'(1);
              end else begin
                length <= eff_len;
              end
              // any load leaves the array open unless last_in closes it
              load_complete <= last_in;
            end else if (length == nlp_pkg::LEN_W'(1)) begin
              // single element never has an ascent
              wrap  <= 1'b1;
              k     <= '0;
              state <= S_EM_RD;
            end else if (length != '0) begin
              wrap  <= 1'b0;
              k     <= len_m1[nlp_pkg::IDX_W-1:0];
              state <= S_ASC_RD;
            end
          end
        end
        S_ASC_RD: begin
          state <= S_ASC_CMP;
        end
        S_ASC_CMP: begin
          prev <= ram_rdata;
          if ((nlp_pkg::LEN_W'(k) != len_m1) && (ram_rdata < prev)) begin
            pivot <= k;
            pv    <= ram_rdata;
            j     <= len_m1[nlp_pkg::IDX_W-1:0];
            state <= S_SUC_RD;
          end else if (k == '0) begin
            // no ascent: reverse the whole array
            wrap      <= 1'b1;
            lo        <= '0;
            hi        <= len_m1[nlp_pkg::IDX_W-1:0];
            rev_phase <= 1'b1;
            state     <= S_CHK;
          end else begin
            k     <= k - nlp_pkg::IDX_W'(1);
            state <= S_ASC_RD;
          end
        end
        S_SUC_RD: begin
          state <= S_SUC_CMP;
        end
        S_SUC_CMP: begin
          if (pv < ram_rdata) begin
            lo        <= pivot;
            hi        <= j;
            rev_phase <= 1'b0;
            state     <= S_RD_LO;
          end else begin
            j     <= j - nlp_pkg::IDX_W'(1);
            state <= S_SUC_RD;
          end
        end
        S_RD_LO: begin
          state <= S_RD_HI;
        end
        S_RD_HI: begin
          tmp   <= ram_rdata;
          state <= S_WR_LO;
        end
        S_WR_LO: begin
          state <= S_WR_HI;
        end
        S_WR_HI: begin
          if (rev_phase) begin
            lo <= lo + nlp_pkg::IDX_W'(1);
            hi <= hi - nlp_pkg::IDX_W'(1);
          end else begin
            // pivot swap done, reverse the suffix
            lo        <= pivot + nlp_pkg::IDX_W'(1);
            hi        <= len_m1[nlp_pkg::IDX_W-1:0];
            rev_phase <= 1'b1;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          if (lo < hi) begin
            state <= S_RD_LO;
          end else begin
            k     <= '0;
            state <= S_EM_RD;
          end
        end
        S_EM_RD: begin
          state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          // ram read data stays put while the output register is stalled
          if (out_free) begin
            out_valid  <= 1'b1;
            elem_value <= nlp_pkg::ELEM_W'(ram_rdata);
            position   <= nlp_pkg::POS_W'(k);
            last_out   <= emit_last;
            wrapped    <= wrap;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + nlp_pkg::IDX_W'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `NLP_ASSERT_ALWAYS(a_len_cap, length <= nlp_pkg::LEN_W'(nlp_pkg::MAX_LEN))
  `NLP_ASSERT_IMP(a_succ_right_of_pivot, state == S_SUC_CMP, j > pivot)
  `NLP_ASSERT_IMP(a_rev_in_range, state == S_CHK, nlp_pkg::LEN_W'(hi) < length)
  `NLP_ASSERT_NEXT(a_load_only_when_idle, ram_we && (state == S_IDLE), state == S_IDLE)
endmodule
